[hw/rtl/cepi_pkg.sv]
// ----------------------------------------------------------------------------
// cepi_pkg
// shared types, constants and the ease table arithmetic for the cosine eased
// pose interpolator
// ----------------------------------------------------------------------------
`default_nettype none

package cepi_pkg;

  // field widths
  localparam int POS_W       = 10;
  localparam int STEP_W      = 7;
  localparam int EASE_W      = 17;
  localparam int EASE_FRAC_W = 16;
  localparam int AXES        = 3;

  // signed difference times signed-extended ease factor
  localparam int PROD_W = (POS_W + 1) + (EASE_W + 1);

  // step count limits and register reset
  localparam int MAX_STEPS        = 64;
  localparam int STEP_COUNT_RESET = 20;

  // configuration port
  localparam int   CFG_ADDR_W     = 3;
  localparam int   CFG_DATA_W     = 32;
  localparam logic REG_STEP_COUNT = 1'b0;

  // ease table constants
  localparam logic [EASE_W-1:0] EASE_ONE = 17'd65536;
  localparam logic [63:0] PI_Q30    = 64'd3373259426;
  localparam logic [63:0] Q30_HALF  = 64'd536870912;
  localparam int TAYLOR_TERMS = 10;
  // (2k-1)(2k) for k = 1..10
  localparam logic [15:0] TAYLOR_DIV [TAYLOR_TERMS] = '{
    16'd2, 16'd12, 16'd30, 16'd56, 16'd90,
    16'd132, 16'd182, 16'd240, 16'd306, 16'd380
  };

  typedef logic [POS_W-1:0]  pos_t;
  typedef logic [STEP_W-1:0] step_t;

  // controller to datapath
  typedef struct packed {
    logic load;
    logic div_step;
    logic rom_read;
    logic mul;
    logic emit;
  } cepi_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic div_last;
    logic step_last;
    logic out_free;
  } cepi_sts_t;

  // half of (1 - cos(angle)) in Q16, angle in Q30, evaluated at elaboration
  function automatic logic [EASE_W-1:0] ease_half(input logic [63:0] angle);
    logic [63:0]        x2;
    logic [63:0]        term;
    logic signed [63:0] sum;
    logic [63:0]        scaled;
    x2   = (angle * angle) >> 30;
    term = 64'd1 << 30;
    sum  = '0;
    for (int k = 0; k < TAYLOR_TERMS; k++) begin
      term = (term * x2) >> 30;
      term = term / 64'(TAYLOR_DIV[k]);
      if ((k & 1) == 0) begin
        sum = sum + $signed(term);
      end else begin
        sum = sum - $signed(term);
      end
    end
    if (sum < 0) begin
      sum = '0;
    end
    scaled = ($unsigned(sum) * 64'd32768 + Q30_HALF) >> 30;
    return EASE_W'(scaled);
  endfunction

endpackage

`default_nettype wire

[hw/rtl/cepi_ctrl.sv]
// ----------------------------------------------------------------------------
// cepi_ctrl
// sequencer for one move: step-size division, then per step a table read,
// a multiply and a setpoint transfer
// ----------------------------------------------------------------------------
`default_nettype none

module cepi_ctrl
  import cepi_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      in_valid,
  output logic           in_stall,
  input  wire cepi_sts_t sts_i,
  output cepi_cmd_t      cmd_o
);

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_DIV  = 5'b00010,
    S_READ = 5'b00100,
    S_MUL  = 5'b01000,
    S_EMIT = 5'b10000
  } state_t;

  state_t state_r;
  state_t state_nxt;

  // next state and commands
  always_comb begin
    cmd_o     = '0;
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd_o.load = 1'b1;
          state_nxt  = S_DIV;
        end
      end
      S_DIV: begin
        cmd_o.div_step = 1'b1;
        if (sts_i.div_last) begin
          state_nxt = S_READ;
        end
      end
      S_READ: begin
        cmd_o.rom_read = 1'b1;
        state_nxt      = S_MUL;
      end
      S_MUL: begin
        cmd_o.mul = 1'b1;
        state_nxt = S_EMIT;
      end
      S_EMIT: begin
        // hold the step until the output register can take it
        if (sts_i.out_free) begin
          cmd_o.emit = 1'b1;
          state_nxt  = sts_i.step_last ? S_IDLE : S_READ;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // requests are taken only between moves
  assign in_stall = (state_r != S_IDLE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // an accepted request always starts the divider
  a_load_starts_div: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> (state_r == S_DIV))
    else $error("request accepted without entering the divide phase");

  // the last step transfer frees the input side on the next cycle
  a_last_step_frees_input: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd_o.emit && sts_i.step_last) |=> !in_stall)
    else $error("input still stalled after the last step of a move");

endmodule

`default_nettype wire

[hw/rtl/cepi_datapath.sv]
// ----------------------------------------------------------------------------
// cepi_datapath
// latched move, step-size divider, ease table, three multiply lanes and the
// output register
// ----------------------------------------------------------------------------
`default_nettype none

module cepi_datapath
  import cepi_pkg::*;
#(
  parameter int EASE_TABLE_SIZE = 1024
) (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire cepi_cmd_t cmd_i,
  output cepi_sts_t      sts_o,
  input  wire step_t     step_count_i,
  input  wire pos_t      in_current [AXES],
  input  wire pos_t      in_goal [AXES],
  output logic           out_valid,
  input  wire logic      out_stall,
  output pos_t           out_setpoint [AXES],
  output step_t          out_step_number,
  output logic           out_final_step
);

  localparam int IW      = $clog2(EASE_TABLE_SIZE + 1);
  localparam int CW      = $clog2(IW);
  localparam int DELTA_W = PROD_W - EASE_FRAC_W;
  localparam int SUM_W   = DELTA_W + 1;
  localparam logic [IW-1:0] TABLE_BITS = IW'(EASE_TABLE_SIZE);
  localparam logic [CW-1:0] DIV_FIRST  = CW'(IW - 1);

  // ease table, built at elaboration; upper half mirrors the lower half
  logic [EASE_W-1:0] ease_rom [EASE_TABLE_SIZE + 1];

  for (genvar g = 0; g <= EASE_TABLE_SIZE; g++) begin : g_rom
    localparam bit LOW_HALF = (2 * g <= EASE_TABLE_SIZE);
    localparam int HALF_IDX = LOW_HALF ? g : EASE_TABLE_SIZE - g;
    localparam logic [63:0] ANGLE = (PI_Q30 * 64'(HALF_IDX)) / 64'(EASE_TABLE_SIZE);
    localparam logic [EASE_W-1:0] HALF_VAL = ease_half(ANGLE);
    assign ease_rom[g] = LOW_HALF ? HALF_VAL : EASE_W'(EASE_ONE - HALF_VAL);
  end

  // latched move
  pos_t  cur_r [AXES];
  pos_t  goal_r [AXES];
  step_t n_r;
  step_t s_r;
  step_t n_sat;

  // divider: quo_r and rem_r end up as table_size / n and its remainder
  logic [IW-1:0] quo_r;
  step_t         rem_r;
  logic [CW-1:0] div_cnt_r;
  logic [CW-1:0] div_cnt_nxt;
  logic [STEP_W:0] div_shift;
  logic          div_ge;
  step_t         div_rem;
  logic [IW-1:0] div_quo;

  // table index for the current step, kept as quotient and fraction
  logic [IW-1:0] idx_r;
  step_t         frac_r;
  logic [STEP_W:0] frac_sum;
  logic          frac_wrap;
  step_t         frac_adv;
  logic [IW-1:0] idx_adv;

  // multiply lanes
  logic [EASE_W-1:0]        ease_r;
  logic signed [POS_W:0]    diff [AXES];
  logic signed [PROD_W-1:0] mul_res [AXES];
  logic signed [PROD_W-1:0] prod_r [AXES];
  logic signed [DELTA_W-1:0] delta [AXES];
  logic [SUM_W-1:0]         sp_sum [AXES];
  pos_t                     sp [AXES];

  // output register
  logic  out_valid_r;
  logic  out_valid_nxt;
  pos_t  out_sp_r [AXES];
  step_t out_step_r;
  logic  out_final_r;

  // effective step count
  always_comb begin
    if (step_count_i == '0) begin
      n_sat = STEP_W'(1);
    end else if (step_count_i > STEP_W'(MAX_STEPS)) begin
      n_sat = STEP_W'(MAX_STEPS);
    end else begin
      n_sat = step_count_i;
    end
  end

  // one restoring division step per cycle, table size bits msb first
  always_comb begin
    div_shift   = {rem_r, TABLE_BITS[div_cnt_r]};
    div_ge      = (div_shift >= {1'b0, n_r});
    div_rem     = div_ge ? STEP_W'(div_shift - {1'b0, n_r}) : div_shift[STEP_W-1:0];
    div_quo     = {quo_r[IW-2:0], div_ge};
    div_cnt_nxt = div_cnt_r - CW'(1);
  end

  // index for the next step: add quotient, carry from the fraction
  always_comb begin
    frac_sum  = {1'b0, frac_r} + {1'b0, rem_r};
    frac_wrap = (frac_sum >= {1'b0, n_r});
    frac_adv  = frac_wrap ? STEP_W'(frac_sum - {1'b0, n_r}) : frac_sum[STEP_W-1:0];
    idx_adv   = idx_r + quo_r + IW'(frac_wrap);
  end

  // per-axis product and floored setpoint
  always_comb begin
    for (int a = 0; a < AXES; a++) begin
      diff[a]    = $signed({1'b0, goal_r[a]}) - $signed({1'b0, cur_r[a]});
      mul_res[a] = diff[a] * $signed({1'b0, ease_r});
      delta[a]   = prod_r[a][PROD_W-1:EASE_FRAC_W];
      sp_sum[a]  = SUM_W'({1'b0, cur_r[a]}) +
                   {{(SUM_W - DELTA_W){delta[a][DELTA_W-1]}}, delta[a]};
      sp[a]      = sp_sum[a][POS_W-1:0];
    end
  end

  // output register occupancy
  always_comb begin
    if (cmd_i.emit) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      div_cnt_r   <= '0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (cmd_i.load) begin
        div_cnt_r <= DIV_FIRST;
      end else if (cmd_i.div_step) begin
        div_cnt_r <= div_cnt_nxt;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (cmd_i.load) begin
      for (int a = 0; a < AXES; a++) begin
        cur_r[a]  <= in_current[a];
        goal_r[a] <= in_goal[a];
      end
      n_r   <= n_sat;
      s_r   <= STEP_W'(1);
      quo_r <= '0;
      rem_r <= '0;
    end
    if (cmd_i.div_step) begin
      quo_r <= div_quo;
      rem_r <= div_rem;
      // first step sits at one quotient into the table
      if (div_cnt_r == '0) begin
        idx_r  <= div_quo;
        frac_r <= div_rem;
      end
    end
    if (cmd_i.rom_read) begin
      ease_r <= ease_rom[idx_r];
    end
    if (cmd_i.mul) begin
      for (int a = 0; a < AXES; a++) begin
        prod_r[a] <= mul_res[a];
      end
    end
    if (cmd_i.emit) begin
      for (int a = 0; a < AXES; a++) begin
        out_sp_r[a] <= sp[a];
      end
      out_step_r  <= s_r;
      out_final_r <= (s_r == n_r);
      s_r         <= s_r + STEP_W'(1);
      idx_r       <= idx_adv;
      frac_r      <= frac_adv;
    end
  end

  assign sts_o.div_last  = (div_cnt_r == '0);
  assign sts_o.step_last = (s_r == n_r);
  assign sts_o.out_free  = !out_valid_r || !out_stall;

  assign out_valid       = out_valid_r;
  assign out_setpoint    = out_sp_r;
  assign out_step_number = out_step_r;
  assign out_final_step  = out_final_r;

  // a step must never overwrite a result that is still waiting
  a_emit_into_free_slot: assert property (@(posedge clk) disable iff (!rst_n)
    cmd_i.emit |-> (!out_valid_r || !out_stall))
    else $error("setpoint loaded over a pending transfer");

  // the last step of every move reads the final table entry
  a_last_step_full_ease: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd_i.emit && (s_r == n_r)) |-> (idx_r == TABLE_BITS))
    else $error("last step does not land on the end of the ease table");

  // the index fraction stays a proper remainder
  a_frac_below_count: assert property (@(posedge clk) disable iff (!rst_n)
    cmd_i.rom_read |-> (frac_r < n_r))
    else $error("index fraction not below the step count");

endmodule

`default_nettype wire

[hw/rtl/cosine_eased_pose_interpolator_top.sv]
// ----------------------------------------------------------------------------
// cosine_eased_pose_interpolator_top
// cosine eased three-axis move interpolator with a step count register
// ----------------------------------------------------------------------------
// A move request (present and target position of three axes) is a transfer
// on the in_ channel: in_valid high and in_stall low at a rising edge. For a
// step count N (register 0, 0 read as 1, above 64 held at 64) the block
// sends N setpoint transfers on the out_ channel, steps 1..N, the last one
// flagged by out_final_step and equal to the target.
// Sequence with no output stall: the request is latched, the bit-serial
// step-size divider works through the W = clog2(EASE_TABLE_SIZE + 1) bits
// (11 at 1024) of the table size, then each step runs a table read, a
// multiply and the setpoint register in turn. The next request is taken
// right after the last setpoint is registered, while that setpoint may
// still be waiting.
// While out_stall is high the pending setpoint holds and the sequencer waits
// for the output register to free up; nothing is dropped.
// Reset (rst_n low, synchronous) empties the output register, returns the
// sequencer to idle and sets the step count to 20.
// The configuration port is APB style, pready always high, register 0 at
// byte address 0; writes are meant for idle periods only.
// ----------------------------------------------------------------------------
`default_nettype none

module cosine_eased_pose_interpolator_top
  import cepi_pkg::*;
#(
  parameter int EASE_TABLE_SIZE = 1024
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  // request channel
  input  wire logic                  in_valid,
  output logic                       in_stall,
  input  wire pos_t                  in_current_axis0,
  input  wire pos_t                  in_current_axis1,
  input  wire pos_t                  in_current_axis2,
  input  wire pos_t                  in_goal_axis0,
  input  wire pos_t                  in_goal_axis1,
  input  wire pos_t                  in_goal_axis2,
  // setpoint channel
  output logic                       out_valid,
  input  wire logic                  out_stall,
  output pos_t                       out_setpoint_axis0,
  output pos_t                       out_setpoint_axis1,
  output pos_t                       out_setpoint_axis2,
  output step_t                      out_step_number,
  output logic                       out_final_step,
  // configuration port
  input  wire logic                  psel,
  input  wire logic                  penable,
  input  wire logic                  pwrite,
  input  wire logic [CFG_ADDR_W-1:0] paddr,
  input  wire logic [CFG_DATA_W-1:0] pwdata,
  output logic [CFG_DATA_W-1:0]      prdata,
  output logic                       pready
);

  step_t     step_count_r;
  logic      reg_sel;
  logic      cfg_wr;
  cepi_cmd_t cmd;
  cepi_sts_t sts;
  pos_t      cur [AXES];
  pos_t      goal [AXES];
  pos_t      setpoint [AXES];

  // register decode
  assign pready  = 1'b1;
  assign reg_sel = (paddr[CFG_ADDR_W-1:2] == REG_STEP_COUNT);
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign prdata  = reg_sel ? CFG_DATA_W'(step_count_r) : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_count_r <= STEP_W'(STEP_COUNT_RESET);
    end else if (cfg_wr && reg_sel) begin
      step_count_r <= pwdata[STEP_W-1:0];
    end
  end

  // axis bundling
  assign cur[0]  = in_current_axis0;
  assign cur[1]  = in_current_axis1;
  assign cur[2]  = in_current_axis2;
  assign goal[0] = in_goal_axis0;
  assign goal[1] = in_goal_axis1;
  assign goal[2] = in_goal_axis2;

  assign out_setpoint_axis0 = setpoint[0];
  assign out_setpoint_axis1 = setpoint[1];
  assign out_setpoint_axis2 = setpoint[2];

  // sequencer
  cepi_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts_i    (sts),
    .cmd_o    (cmd)
  );

  // arithmetic and output register
  cepi_datapath #(
    .EASE_TABLE_SIZE (EASE_TABLE_SIZE)
  ) u_datapath (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd_i           (cmd),
    .sts_o           (sts),
    .step_count_i    (step_count_r),
    .in_current      (cur),
    .in_goal         (goal),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_setpoint    (setpoint),
    .out_step_number (out_step_number),
    .out_final_step  (out_final_step)
  );

endmodule

`default_nettype wire

[sim/setpoint_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// setpoint_checker
// watches the move request, setpoint and register ports of the cosine eased
// pose interpolator, predicts every setpoint of each accepted move from its
// own ease table and compares the setpoints in order as they are transferred
// ----------------------------------------------------------------------------
module setpoint_checker
  import cepi_pkg::*;
#(
  parameter int TABLE_SIZE = 1024
) (
  input  logic                  clk,
  input  logic                  rst_n,
  // move request channel
  input  logic                  in_valid,
  input  logic                  in_stall,
  input  pos_t                  in_current_axis0,
  input  pos_t                  in_current_axis1,
  input  pos_t                  in_current_axis2,
  input  pos_t                  in_goal_axis0,
  input  pos_t                  in_goal_axis1,
  input  pos_t                  in_goal_axis2,
  // setpoint channel
  input  logic                  out_valid,
  input  logic                  out_stall,
  input  pos_t                  out_setpoint_axis0,
  input  pos_t                  out_setpoint_axis1,
  input  pos_t                  out_setpoint_axis2,
  input  step_t                 out_step_number,
  input  logic                  out_final_step,
  // register port
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic                  pready,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [CFG_DATA_W-1:0] pwdata,
  // to the testbench top
  output int                    failures,
  output int                    pending_count
);

  // pi in Q30 and the length of the 1 - cos series
  localparam logic [63:0] HALF_TURN_Q30 = 64'd3373259426;
  localparam int          SERIES_TERMS  = 10;
  localparam int          REPORT_LIMIT  = 10;

  typedef pos_t [AXES-1:0] pose_t;

  typedef struct packed {
    pos_t  axis0;
    pos_t  axis1;
    pos_t  axis2;
    step_t index;
    logic  last;
  } setpoint_t;

  logic [EASE_W-1:0] ease_lut [0:TABLE_SIZE];
  step_t             steps_per_move;
  setpoint_t         due_setpoints [$];

  // half of (1 - cos(pi * i / TABLE_SIZE)) in Q16, for the lower half of the table
  function automatic logic [EASE_W-1:0] raised_cosine_q16(input int unsigned i);
    logic [63:0]        angle;
    logic [63:0]        angle_sq;
    logic [63:0]        term;
    logic signed [63:0] acc;
    angle    = (HALF_TURN_Q30 * 64'(i)) / 64'(TABLE_SIZE);
    angle_sq = (angle * angle) >> 30;
    term     = 64'd1 << 30;
    acc      = '0;
    for (int k = 1; k <= SERIES_TERMS; k++) begin
      term = (term * angle_sq) >> 30;
      term = term / 64'((2 * k - 1) * (2 * k));
      if (k % 2 == 1) begin
        acc = acc + $signed(term);
      end else begin
        acc = acc - $signed(term);
      end
    end
    if (acc < 0) begin
      acc = '0;
    end
    return EASE_W'(($unsigned(acc) * 64'd32768 + (64'd1 << 29)) >> 30);
  endfunction

  // upper half mirrors the lower half around one half
  initial begin
    for (int i = 0; i <= TABLE_SIZE; i++) begin
      if (2 * i <= TABLE_SIZE) begin
        ease_lut[i] = raised_cosine_q16(i);
      end else begin
        ease_lut[i] = EASE_ONE - ease_lut[TABLE_SIZE - i];
      end
    end
  end

  // start plus floor of span times ease, kept within the 10 bit field
  function automatic pos_t eased_position(input pos_t start, input pos_t goal,
                                          input logic [EASE_W-1:0] ease);
    int span;
    int scaled;
    span   = int'(goal) - int'(start);
    scaled = span * int'(ease);
    return pos_t'(int'(start) + (scaled >>> EASE_FRAC_W));
  endfunction

  // queue every setpoint of one move
  function automatic void plan_move(input pose_t start_pos, input pose_t goal_pos);
    int                moves;
    logic [EASE_W-1:0] ease;
    setpoint_t         sp;
    if (steps_per_move == 0) begin
      moves = 1;
    end else if (steps_per_move > MAX_STEPS) begin
      moves = MAX_STEPS;
    end else begin
      moves = int'(steps_per_move);
    end
    for (int s = 1; s <= moves; s++) begin
      ease     = ease_lut[(s * TABLE_SIZE) / moves];
      sp.axis0 = eased_position(start_pos[0], goal_pos[0], ease);
      sp.axis1 = eased_position(start_pos[1], goal_pos[1], ease);
      sp.axis2 = eased_position(start_pos[2], goal_pos[2], ease);
      sp.index = step_t'(s);
      sp.last  = (s == moves);
      due_setpoints.push_back(sp);
    end
  endfunction

  always @(posedge clk) begin : watch
    setpoint_t seen;
    setpoint_t want;
    if (!rst_n) begin
      steps_per_move = step_t'(STEP_COUNT_RESET);
      due_setpoints.delete();
      failures = 0;
    end else begin
      // register write transfer
      if (psel && penable && pwrite && pready && paddr[CFG_ADDR_W-1:2] == REG_STEP_COUNT) begin
        steps_per_move = pwdata[STEP_W-1:0];
      end

      // setpoint transfer against the oldest prediction
      if (out_valid && !out_stall) begin
        seen.axis0 = out_setpoint_axis0;
        seen.axis1 = out_setpoint_axis1;
        seen.axis2 = out_setpoint_axis2;
        seen.index = out_step_number;
        seen.last  = out_final_step;
        if (due_setpoints.size() == 0) begin
          if (failures < REPORT_LIMIT) begin
            $display("%0t: setpoint with no move pending: %0d %0d %0d step %0d final %0b",
                     $time, seen.axis0, seen.axis1, seen.axis2, seen.index, seen.last);
          end
          failures++;
        end else begin
          want = due_setpoints.pop_front();
          if (seen.axis0 !== want.axis0 || seen.axis1 !== want.axis1 ||
              seen.axis2 !== want.axis2 || seen.index !== want.index ||
              seen.last !== want.last) begin
            if (failures < REPORT_LIMIT) begin
              $display("%0t: setpoint mismatch: expected %0d %0d %0d step %0d final %0b",
                       $time, want.axis0, want.axis1, want.axis2, want.index, want.last);
              $display("%0t:                    got      %0d %0d %0d step %0d final %0b",
                       $time, seen.axis0, seen.axis1, seen.axis2, seen.index, seen.last);
            end
            failures++;
          end
        end
      end

      // move request transfer
      if (in_valid && !in_stall) begin
        plan_move({in_current_axis2, in_current_axis1, in_current_axis0},
                  {in_goal_axis2, in_goal_axis1, in_goal_axis0});
      end
    end
    pending_count = due_setpoints.size();
  end

endmodule

[sim/testbench.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// drives move requests and step count writes into the cosine eased pose
// interpolator with random sender gaps and receiver stalls; the setpoint
// checker beside the block predicts and compares, this module gives the verdict
// ----------------------------------------------------------------------------
module testbench
  import cepi_pkg::*;
();

  localparam int EASE_TABLE_SIZE = 1024;
  localparam int RESET_CYCLES    = 2;
  localparam int RANDOM_MOVES    = 470;
  localparam int PHASES          = 10;
  // divider plus pipeline of the block, with some margin
  localparam int SETTLE_CYCLES   = 20;
  localparam int DRAIN_CYCLES    = 60;
  localparam int MAX_STALL_RUN   = 8;
  localparam int STALL_WINDOW    = 256;
  // ~500 moves at the maximum step count with the longest stall runs, taken several times
  localparam int CYCLE_LIMIT     = 2_000_000;

  localparam pos_t POS_MAX = '1;
  localparam logic [CFG_ADDR_W-1:0] ADDR_STEP_COUNT = {REG_STEP_COUNT, 2'b00};
  localparam logic [CFG_ADDR_W-1:0] ADDR_UNMAPPED   = {~REG_STEP_COUNT, 2'b00};

  typedef pos_t [AXES-1:0] pose_t;

  typedef enum logic [1:0] {
    STALL_NONE,
    STALL_LIGHT,
    STALL_HEAVY,
    STALL_PERIODIC
  } stall_mode_t;

  logic                  clk;
  logic                  rst_n;
  logic                  in_valid;
  logic                  in_stall;
  pos_t                  in_current_axis0;
  pos_t                  in_current_axis1;
  pos_t                  in_current_axis2;
  pos_t                  in_goal_axis0;
  pos_t                  in_goal_axis1;
  pos_t                  in_goal_axis2;
  logic                  out_valid;
  logic                  out_stall;
  pos_t                  out_setpoint_axis0;
  pos_t                  out_setpoint_axis1;
  pos_t                  out_setpoint_axis2;
  step_t                 out_step_number;
  logic                  out_final_step;
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [CFG_ADDR_W-1:0] paddr;
  logic [CFG_DATA_W-1:0] pwdata;
  logic [CFG_DATA_W-1:0] prdata;
  logic                  pready;
  int                    failures;
  int                    pending_count;

  cosine_eased_pose_interpolator_top #(
    .EASE_TABLE_SIZE(EASE_TABLE_SIZE)
  ) uut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_current_axis0   (in_current_axis0),
    .in_current_axis1   (in_current_axis1),
    .in_current_axis2   (in_current_axis2),
    .in_goal_axis0      (in_goal_axis0),
    .in_goal_axis1      (in_goal_axis1),
    .in_goal_axis2      (in_goal_axis2),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_setpoint_axis0 (out_setpoint_axis0),
    .out_setpoint_axis1 (out_setpoint_axis1),
    .out_setpoint_axis2 (out_setpoint_axis2),
    .out_step_number    (out_step_number),
    .out_final_step     (out_final_step),
    .psel               (psel),
    .penable            (penable),
    .pwrite             (pwrite),
    .paddr              (paddr),
    .pwdata             (pwdata),
    .prdata             (prdata),
    .pready             (pready)
  );

  setpoint_checker #(
    .TABLE_SIZE(EASE_TABLE_SIZE)
  ) setpoint_check (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_current_axis0   (in_current_axis0),
    .in_current_axis1   (in_current_axis1),
    .in_current_axis2   (in_current_axis2),
    .in_goal_axis0      (in_goal_axis0),
    .in_goal_axis1      (in_goal_axis1),
    .in_goal_axis2      (in_goal_axis2),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_setpoint_axis0 (out_setpoint_axis0),
    .out_setpoint_axis1 (out_setpoint_axis1),
    .out_setpoint_axis2 (out_setpoint_axis2),
    .out_step_number    (out_step_number),
    .out_final_step     (out_final_step),
    .psel               (psel),
    .penable            (penable),
    .pwrite             (pwrite),
    .pready             (pready),
    .paddr              (paddr),
    .pwdata             (pwdata),
    .failures           (failures),
    .pending_count      (pending_count)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // run limit
  initial begin : watchdog
    int cycle_count;
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("simulation failed");
    $finish;
  end

  // receiver: stall pattern changes every window, runs of stall are capped
  initial begin : receiver
    stall_mode_t mode;
    int          run_length;
    int          tick;
    logic        hold;
    out_stall  = 1'b0;
    mode       = STALL_NONE;
    run_length = 0;
    tick       = 0;
    forever begin
      @(negedge clk);
      if (tick % STALL_WINDOW == 0) begin
        mode = stall_mode_t'($urandom_range(0, 3));
      end
      case (mode)
        STALL_NONE:  hold = 1'b0;
        STALL_LIGHT: hold = ($urandom_range(0, 3) == 0);
        STALL_HEAVY: hold = ($urandom_range(0, 3) != 0);
        default:     hold = ((tick % 7) < 3);
      endcase
      if (run_length >= MAX_STALL_RUN) begin
        hold = 1'b0;
      end
      run_length = hold ? run_length + 1 : 0;
      out_stall <= hold;
      tick++;
    end
  end

  function automatic pose_t pose(input pos_t a0, input pos_t a1, input pos_t a2);
    return {a2, a1, a0};
  endfunction

  // mostly full range, with rail values, no move and small moves mixed in
  function automatic pos_t pick_position(input pos_t near);
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return POS_MAX;
      2:       return near;
      3:       return pos_t'(near + $urandom_range(0, 6) - 3);
      default: return pos_t'($urandom);
    endcase
  endfunction

  // one request transfer after gap idle cycles
  task automatic request_move(input pose_t from_pos, input pose_t to_pos, input int gap);
    if (gap > 0) begin
      @(negedge clk);
      in_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_valid         <= 1'b1;
    in_current_axis0 <= from_pos[0];
    in_current_axis1 <= from_pos[1];
    in_current_axis2 <= from_pos[2];
    in_goal_axis0    <= to_pos[0];
    in_goal_axis1    <= to_pos[1];
    in_goal_axis2    <= to_pos[2];
    do @(posedge clk); while (in_stall);
  endtask

  // stop requesting and let every predicted setpoint come out
  task automatic wait_for_idle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_count != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // setup and access cycle, only once the block has gone quiet
  task automatic write_register(input logic [CFG_ADDR_W-1:0] addr,
                                input logic [CFG_DATA_W-1:0] data);
    wait_for_idle();
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  initial begin : stimulus
    pose_t      from_pos;
    pose_t      to_pos;
    pose_t      last_goal;
    int         burst_left;
    int         gap;
    logic [6:0] count_value;

    in_valid         = 1'b0;
    in_current_axis0 = '0;
    in_current_axis1 = '0;
    in_current_axis2 = '0;
    in_goal_axis0    = '0;
    in_goal_axis1    = '0;
    in_goal_axis2    = '0;
    psel             = 1'b0;
    penable          = 1'b0;
    pwrite           = 1'b0;
    paddr            = '0;
    pwdata           = '0;
    last_goal        = '0;
    rst_n            = 1'b0;
    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // reset step count: full swings both ways, no move, mixed axes, bit patterns
    request_move(pose(0, 0, 0), pose(POS_MAX, POS_MAX, POS_MAX), $urandom_range(0, 4));
    request_move(pose(POS_MAX, POS_MAX, POS_MAX), pose(0, 0, 0), $urandom_range(0, 4));
    request_move(pose(512, 512, 512), pose(512, 512, 512), $urandom_range(0, 4));
    request_move(pose(0, POS_MAX, 5), pose(POS_MAX, 0, 5), $urandom_range(0, 4));
    request_move(pose(10'h2AA, 10'h2AA, 10'h2AA), pose(10'h155, 10'h155, 10'h155), 0);
    request_move(pose(10'h155, 10'h155, 10'h155), pose(10'h2AA, 10'h2AA, 10'h2AA), 0);
    request_move(pose(100, 1, 1022), pose(101, 0, POS_MAX), $urandom_range(0, 4));

    // single step moves land on the goal at once
    write_register(ADDR_STEP_COUNT, CFG_DATA_W'(1));
    request_move(pose(0, POS_MAX, 300), pose(POS_MAX, 0, 700), 0);
    request_move(pose(POS_MAX, 0, 0), pose(0, POS_MAX, 0), 0);

    // longest moves
    write_register(ADDR_STEP_COUNT, CFG_DATA_W'(MAX_STEPS));
    request_move(pose(0, POS_MAX, 300), pose(POS_MAX, 0, 301), $urandom_range(0, 4));
    request_move(pose(pos_t'($urandom), pos_t'($urandom), pos_t'($urandom)),
                 pose(pos_t'($urandom), pos_t'($urandom), pos_t'($urandom)), 0);

    // zero count runs as one step
    write_register(ADDR_STEP_COUNT, CFG_DATA_W'(0));
    request_move(pose(0, 0, 0), pose(POS_MAX, POS_MAX, POS_MAX), $urandom_range(0, 4));

    // counts above the maximum are held at the maximum
    write_register(ADDR_STEP_COUNT, CFG_DATA_W'(127));
    request_move(pose(POS_MAX, POS_MAX, POS_MAX), pose(0, 0, 0), 0);
    write_register(ADDR_STEP_COUNT, CFG_DATA_W'(MAX_STEPS + 1));
    request_move(pose(7, 900, 450), pose(1000, 3, 450), 0);

    // bits above the field are dropped
    write_register(ADDR_STEP_COUNT, {25'h1FF_FFFF, 7'd2});
    request_move(pose(0, 512, POS_MAX), pose(POS_MAX, 511, 0), 0);

    // a write past the last register leaves the step count alone
    write_register(ADDR_UNMAPPED, CFG_DATA_W'(40));
    request_move(pose(1, 2, 3), pose(1020, 1021, 1022), $urandom_range(0, 4));
    request_move(pose(1020, 1021, 1022), pose(1, 2, 3), 0);

    // random phases, each under its own step count, requests sent in bursts
    for (int p = 0; p < PHASES; p++) begin
      case (p)
        0:       count_value = 7'd1;
        1:       count_value = 7'(MAX_STEPS);
        2:       count_value = 7'd0;
        3:       count_value = 7'd127;
        4:       count_value = 7'(MAX_STEPS + 1);
        default: count_value = ($urandom_range(0, 3) == 0) ?
                               7'($urandom_range(17, MAX_STEPS)) : 7'($urandom_range(1, 16));
      endcase
      write_register(ADDR_STEP_COUNT, CFG_DATA_W'({$urandom, count_value}));
      if ($urandom_range(0, 1) == 1) begin
        write_register(ADDR_UNMAPPED, $urandom);
      end
      burst_left = 0;
      for (int m = 0; m < RANDOM_MOVES / PHASES; m++) begin
        if (burst_left == 0) begin
          burst_left = $urandom_range(1, ($urandom_range(0, 3) == 0) ? 20 : 5);
          gap        = $urandom_range(1, 30);
        end else begin
          gap = 0;
        end
        burst_left--;
        for (int a = 0; a < AXES; a++) begin
          from_pos[a] = pick_position(last_goal[a]);
          to_pos[a]   = pick_position(from_pos[a]);
        end
        last_goal = to_pos;
        request_move(from_pos, to_pos, gap);
      end
    end

    // drain and verdict
    wait_for_idle();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (failures == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
